[design/sorted_top_k_list_unit_defines.svh]
// Assertion macros for the port-level checker of the sorted top-k list unit.
`ifndef SORTED_TOP_K_LIST_UNIT_DEFINES_SVH
`define SORTED_TOP_K_LIST_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge, quiet in reset.
`define STKL_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, quiet in reset.
`define STKL_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/stkl_pkg.sv]
// Package with the shared types and codes of the sorted top-k list unit.
package stkl_pkg;

    // Operation codes carried on the mode port.
    localparam logic MODE_INSERT = 1'b0;
    localparam logic MODE_QUERY  = 1'b1;

    // Width of a stored value and of the result fields.
    localparam int VALUE_W = 32;
    localparam int RES_W   = 4;

    // Sequencer states.
    typedef enum logic {
        ST_IDLE,
        ST_COMMIT
    } stkl_state_t;

    // Command broadcast from the sequencer to every cell.
    typedef struct packed {
        logic               capture;
        logic               commit;
        logic [VALUE_W-1:0] probe;
        logic [VALUE_W-1:0] key;
    } stkl_cmd_t;

endpackage

[design/stkl_cell.sv]
// One slot of the sorted list: holds an entry, compares it and shifts it on.
module stkl_cell
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  stkl_pkg::stkl_cmd_t           cmd,
    input  logic                          prev_lt,
    input  logic [stkl_pkg::VALUE_W-1:0]  prev_value,
    input  logic                          prev_valid,
    output logic [stkl_pkg::VALUE_W-1:0]  value,
    output logic                          valid,
    output logic                          lt,
    output logic                          eq
);

    logic [stkl_pkg::VALUE_W-1:0] entry_reg;
    logic [stkl_pkg::VALUE_W-1:0] entry_next;
    logic                         valid_reg;
    logic                         valid_next;
    logic                         lt_reg;
    logic                         lt_next;
    logic                         eq_reg;
    logic                         eq_next;
    logic                         take_new;
    logic                         take_prev;

    // Compare stage: the flags are captured when a beat is accepted.
    always_comb
    begin
        lt_next = lt_reg;
        eq_next = eq_reg;
        if (cmd.capture)
        begin
            lt_next = valid_reg && (entry_reg < cmd.probe);
            eq_next = valid_reg && (entry_reg == cmd.probe);
        end
    end

    // Commit stage: the first slot not below the key takes it, and every
    // slot behind that one takes the old contents of its neighbour.
    assign take_new  = cmd.commit && !lt_reg && prev_lt;
    assign take_prev = cmd.commit && !prev_lt;

    always_comb
    begin
        entry_next = entry_reg;
        valid_next = valid_reg;
        if (take_new)
        begin
            entry_next = cmd.key;
            valid_next = 1'b1;
        end
        else if (take_prev)
        begin
            entry_next = prev_value;
            valid_next = prev_valid;
        end
    end

    // Control flags are reset; the stored value is only read where valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            lt_reg    <= 1'b0;
            eq_reg    <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            lt_reg    <= lt_next;
            eq_reg    <= eq_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign value = entry_reg;
    assign valid = valid_reg;
    assign lt    = lt_reg;
    assign eq    = eq_reg;

endmodule

[design/sorted_top_k_list_unit.sv]
// Sorted top-k list unit: a beat is taken when start is high and busy is low.
// Every cell compares its entry with the value in the cycle of acceptance and
// registers the outcome; in the following cycle (busy high) the cells shift
// and an inserted value is written unless already held or above a full list.
// The result beat (done, rank, filled) is registered from the commit state
// and stays for exactly one cycle, since the receiver cannot hold it off; a
// new beat can be taken while it is shown. The sequence does not depend on
// DEPTH. No clearing pass is needed after reset.
module sorted_top_k_list_unit
#(
    parameter int DEPTH = 10
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic                          mode,
    input  logic [stkl_pkg::VALUE_W-1:0]  value,
    output logic                          done,
    output logic [stkl_pkg::RES_W-1:0]    rank,
    output logic [stkl_pkg::RES_W-1:0]    filled
);

    localparam int CNT_W = $clog2(DEPTH + 1);

    stkl_pkg::stkl_state_t        state_reg;
    stkl_pkg::stkl_state_t        state_next;
    logic                         mode_reg;
    logic [stkl_pkg::VALUE_W-1:0] key_reg;
    logic                         done_reg;
    logic                         done_next;
    logic [CNT_W-1:0]             rank_reg;
    logic [CNT_W-1:0]             rank_next;
    logic [CNT_W-1:0]             fill_reg;
    logic [CNT_W-1:0]             fill_next;

    logic                         capture;
    logic                         commit_phase;
    logic                         ins_en;
    logic                         dup;
    logic                         full_miss;
    logic                         hit;
    logic [CNT_W-1:0]             pos;
    logic [DEPTH-1:0]             slot_oh;
    logic [31:0]                  rank_wide;
    logic [31:0]                  fill_wide;

    stkl_pkg::stkl_cmd_t          cmd;
    logic [stkl_pkg::VALUE_W-1:0] cell_value [DEPTH];
    logic [DEPTH-1:0]             cell_valid;
    logic [DEPTH-1:0]             cell_lt;
    logic [DEPTH-1:0]             cell_eq;

    // Next state of the sequencer.
    always_comb
    begin
        case (state_reg)
            stkl_pkg::ST_IDLE:   state_next = start ? stkl_pkg::ST_COMMIT : stkl_pkg::ST_IDLE;
            stkl_pkg::ST_COMMIT: state_next = stkl_pkg::ST_IDLE;
            default:             state_next = stkl_pkg::ST_IDLE;
        endcase
    end

    // Outputs of the sequencer.
    always_comb
    begin
        case (state_reg)
            stkl_pkg::ST_IDLE:
            begin
                busy         = 1'b0;
                capture      = start;
                commit_phase = 1'b0;
            end
            stkl_pkg::ST_COMMIT:
            begin
                busy         = 1'b1;
                capture      = 1'b0;
                commit_phase = 1'b1;
            end
            default:
            begin
                busy         = 1'b0;
                capture      = 1'b0;
                commit_phase = 1'b0;
            end
        endcase
    end

    // Insertion point: the first slot that is not below the key.
    always_comb
    begin
        for (int i = 0; i < DEPTH; i++)
        begin
            if (i == 0)
                slot_oh[i] = !cell_lt[i];
            else
                slot_oh[i] = !cell_lt[i] && cell_lt[i-1];
        end
    end

    // Encode the one-hot slot as its 1-based position.
    always_comb
    begin
        pos = '0;
        for (int i = 0; i < DEPTH; i++)
        begin
            if (slot_oh[i])
                pos = pos | CNT_W'(i + 1);
        end
    end

    assign dup       = |cell_eq;
    assign full_miss = cell_lt[DEPTH-1];
    assign ins_en    = commit_phase && (mode_reg == stkl_pkg::MODE_INSERT) && !dup
                       && !full_miss;
    assign hit       = (mode_reg == stkl_pkg::MODE_QUERY) ? dup : !full_miss;

    // Command broadcast to the chain.
    always_comb
    begin
        cmd.capture = capture;
        cmd.commit  = ins_en;
        cmd.probe   = value;
        cmd.key     = key_reg;
    end

    // The chain of cells; the head has no neighbour and always sees "below".
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_head
            stkl_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .prev_lt    (1'b1),
                .prev_value ('0),
                .prev_valid (1'b0),
                .value      (cell_value[g]),
                .valid      (cell_valid[g]),
                .lt         (cell_lt[g]),
                .eq         (cell_eq[g])
            );
        end
        else
        begin : g_body
            stkl_cell u_cell
            (
                .clk        (clk),
                .rst_n      (rst_n),
                .cmd        (cmd),
                .prev_lt    (cell_lt[g-1]),
                .prev_value (cell_value[g-1]),
                .prev_valid (cell_valid[g-1]),
                .value      (cell_value[g]),
                .valid      (cell_valid[g]),
                .lt         (cell_lt[g]),
                .eq         (cell_eq[g])
            );
        end
    end

    // Result beat and fill count.
    always_comb
    begin
        done_next = commit_phase;
        rank_next = rank_reg;
        fill_next = fill_reg;
        if (commit_phase)
        begin
            rank_next = hit ? pos : '0;
            if (ins_en && !cell_valid[DEPTH-1])
                fill_next = fill_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= stkl_pkg::ST_IDLE;
            done_reg  <= 1'b0;
            fill_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= done_next;
            fill_reg  <= fill_next;
        end
    end

    // Beat payload, held from acceptance to commit.
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            mode_reg <= mode;
            key_reg  <= value;
        end
        rank_reg <= rank_next;
    end

    // Results are reported modulo the width of the result fields.
    assign rank_wide = 32'(rank_reg);
    assign fill_wide = 32'(fill_reg);
    assign done      = done_reg;
    assign rank      = rank_wide[stkl_pkg::RES_W-1:0];
    assign filled    = fill_wide[stkl_pkg::RES_W-1:0];

endmodule

[design/stkl_checker.sv]
// Port-level checker of the sorted top-k list unit and its bind statement.
`include "sorted_top_k_list_unit_defines.svh"

module stkl_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          start,
    input logic                          busy,
    input logic                          mode,
    input logic [stkl_pkg::VALUE_W-1:0]  value,
    input logic                          done,
    input logic [stkl_pkg::RES_W-1:0]    rank,
    input logic [stkl_pkg::RES_W-1:0]    filled
);

    logic accept;

    assign accept = start && !busy;

    // An accepted beat makes the unit busy for one cycle, then reports.
    `STKL_ASSERT_NEXT(a_accept_busy, accept, busy && !done, "accepted beat did not raise busy")
    `STKL_ASSERT_NEXT(a_busy_done, busy, done && !busy, "busy cycle not followed by a result")
    // A result beat is shown only while the unit can take the next beat.
    `STKL_ASSERT_NOW(a_done_idle, done, !busy, "result beat while busy")
    // The fill count moves only with a result beat.
    `STKL_ASSERT_NOW(a_fill_moves, !$stable(filled), done, "fill count changed without a result")

endmodule

bind sorted_top_k_list_unit stkl_checker u_stkl_checker (.*);

[tb/sv/sorted_top_k_list_checker.sv]
// Checker that predicts and compares every result beat of the sorted top-k list unit.
module sorted_top_k_list_checker
#(
    parameter int DEPTH = 10
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    input  logic                          busy,
    input  logic                          mode,
    input  logic [stkl_pkg::VALUE_W-1:0]  value,
    input  logic                          done,
    input  logic [stkl_pkg::RES_W-1:0]    rank,
    input  logic [stkl_pkg::RES_W-1:0]    filled,
    output int                            fail_count,
    output int                            outstanding
);
    import stkl_pkg::*;

    // Position and fill level that one command should report.
    typedef struct packed {
        logic [RES_W-1:0] pos;
        logic [RES_W-1:0] count;
    } rank_fill_t;

    // Shadow copy of the list, kept in ascending order with a valid prefix.
    logic [VALUE_W-1:0] kept_val [DEPTH];
    logic               kept_ok  [DEPTH];

    rank_fill_t rank_fill_due [$];
    int         mismatches = 0;
    int         queued     = 0;

    assign fail_count  = mismatches;
    assign outstanding = queued;

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("%0t sorted_top_k_list_checker: %s got %0d want %0d", $time, what, got, want);
        mismatches++;
    endtask

    // Apply one insert or rank query to the shadow list and return what the
    // block should report for it.
    function automatic rank_fill_t apply_list_step(input logic m, input logic [VALUE_W-1:0] v);
        rank_fill_t r;
        int         slot;
        int         n;
        r    = '0;
        slot = DEPTH;
        if (m == MODE_INSERT)
        begin
            // The first slot that is empty or holds a value not below the new one.
            for (int i = 0; i < DEPTH; i++)
                if (slot == DEPTH && (!kept_ok[i] || kept_val[i] >= v))
                    slot = i;
            if (slot < DEPTH)
            begin
                if (!kept_ok[slot])
                begin
                    kept_val[slot] = v;
                    kept_ok[slot]  = 1'b1;
                end
                else if (kept_val[slot] != v)
                begin
                    // Open a gap: later entries move down and the last one drops off.
                    for (int k = DEPTH - 1; k > slot; k--)
                    begin
                        kept_val[k] = kept_val[k-1];
                        kept_ok[k]  = kept_ok[k-1];
                    end
                    kept_val[slot] = v;
                    kept_ok[slot]  = 1'b1;
                end
            end
        end
        else
        begin
            for (int i = 0; i < DEPTH; i++)
                if (slot == DEPTH && kept_ok[i] && kept_val[i] == v)
                    slot = i;
        end
        if (slot < DEPTH)
            r.pos = RES_W'(slot + 1);
        n = 0;
        for (int i = 0; i < DEPTH; i++)
            if (kept_ok[i])
                n++;
        r.count = RES_W'(n);
        return r;
    endfunction

    // Watch both channels on the rising edge.
    always @(posedge clk)
    begin
        rank_fill_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < DEPTH; i++)
            begin
                kept_ok[i]  = 1'b0;
                kept_val[i] = '0;
            end
            rank_fill_due.delete();
        end
        else
        begin
            // A result beat always belongs to a command taken in an earlier cycle.
            if (done)
            begin
                if (rank_fill_due.size() == 0)
                    report_mismatch("result beat with nothing awaited, rank", rank, 0);
                else
                begin
                    want = rank_fill_due.pop_front();
                    if (rank !== want.pos)
                        report_mismatch("rank", rank, want.pos);
                    if (filled !== want.count)
                        report_mismatch("filled", filled, want.count);
                end
            end
            if (start && !busy)
                rank_fill_due.push_back(apply_list_step(mode, value));
        end
        queued <= rank_fill_due.size();
    end

endmodule

[tb/sv/tb_sorted_top_k_list_unit.sv]
// Testbench top for the sorted top-k list unit: clock, reset, stimulus and verdict.
module tb_sorted_top_k_list_unit;
    import stkl_pkg::*;

    localparam int LIST_DEPTH   = 10;
    localparam int PHASES       = 29;
    localparam int PHASE_BEATS  = 50;
    localparam int QUIET_PHASES = 3;
    localparam int CYCLE_LIMIT  = 300000;
    localparam logic [VALUE_W-1:0] HIGH_BASE = 32'hF000_0000;
    localparam logic [VALUE_W-1:0] TOP_VALUE = 32'hFFFF_FFFF;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               start = 1'b0;
    logic               mode  = MODE_INSERT;
    logic [VALUE_W-1:0] value = '0;
    logic               busy;
    logic               done;
    logic [RES_W-1:0]   rank;
    logic [RES_W-1:0]   filled;
    int                 fail_count;
    int                 outstanding;
    int                 cycles  = 0;
    logic               idle_on = 1'b1;
    logic [VALUE_W-1:0] recent_values [$];

    always #5 clk = ~clk;

    sorted_top_k_list_unit #(.DEPTH(LIST_DEPTH)) uut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .mode   (mode),
        .value  (value),
        .done   (done),
        .rank   (rank),
        .filled (filled)
    );

    sorted_top_k_list_checker #(.DEPTH(LIST_DEPTH)) list_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .mode        (mode),
        .value       (value),
        .done        (done),
        .rank        (rank),
        .filled      (filled),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    // Hard stop in case the block hangs.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("tb_sorted_top_k_list_unit: errors");
            $finish;
        end
    end

    // Offer one command beat, hold it until taken, then perhaps idle a while.
    task automatic send_beat(input logic m, input logic [VALUE_W-1:0] v);
        int gap;
        @(negedge clk);
        start <= 1'b1;
        mode  <= m;
        value <= v;
        do @(posedge clk); while (busy);
        recent_values.push_back(v);
        if (recent_values.size() > 16)
            recent_values.delete(0);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 19);
            @(negedge clk);
            start <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // One random command: mostly values from the current window, some
    // repeats of recent values so that ties and query hits are common.
    task automatic random_beat(input logic [VALUE_W-1:0] base, input int unsigned span);
        int unsigned        pick;
        logic               m;
        logic [VALUE_W-1:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 45)
        begin
            m = MODE_INSERT;
            v = base + $urandom_range(0, span);
        end
        else if (pick < 60)
        begin
            m = MODE_QUERY;
            v = base + $urandom_range(0, span);
        end
        else if (pick < 80)
        begin
            m = ($urandom_range(0, 1) == 0) ? MODE_INSERT : MODE_QUERY;
            v = recent_values[$urandom_range(0, recent_values.size() - 1)];
        end
        else
        begin
            m = ($urandom_range(0, 1) == 0) ? MODE_INSERT : MODE_QUERY;
            v = $urandom;
        end
        send_beat(m, v);
    endtask

    initial
    begin
        logic [VALUE_W-1:0] base;
        int unsigned        span;

        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part: empty list, extremes, ties, filling up, shifting the
        // last entry off, discarding above a full list and missing queries.
        // Large values let the smaller random values push them off the list.
        send_beat(MODE_QUERY,  HIGH_BASE);
        send_beat(MODE_INSERT, TOP_VALUE);
        send_beat(MODE_INSERT, TOP_VALUE);
        send_beat(MODE_INSERT, HIGH_BASE + 500);
        send_beat(MODE_INSERT, HIGH_BASE + 300);
        send_beat(MODE_INSERT, HIGH_BASE + 700);
        send_beat(MODE_INSERT, HIGH_BASE + 100);
        send_beat(MODE_INSERT, HIGH_BASE + 900);
        send_beat(MODE_INSERT, HIGH_BASE + 400);
        send_beat(MODE_INSERT, HIGH_BASE + 800);
        send_beat(MODE_INSERT, '0);
        send_beat(MODE_INSERT, HIGH_BASE + 600);
        send_beat(MODE_INSERT, HIGH_BASE + 1000);
        send_beat(MODE_INSERT, TOP_VALUE);
        send_beat(MODE_INSERT, HIGH_BASE + 1000);
        send_beat(MODE_QUERY,  '0);
        send_beat(MODE_QUERY,  HIGH_BASE + 1000);
        send_beat(MODE_QUERY,  TOP_VALUE);
        send_beat(MODE_QUERY,  HIGH_BASE + 1);
        send_beat(MODE_INSERT, HIGH_BASE + 50);
        send_beat(MODE_QUERY,  HIGH_BASE + 1000);

        // Random part: the value window walks downwards phase by phase, so new
        // values keep landing inside the list instead of being discarded.
        for (int p = 0; p < PHASES; p++)
        begin
            base    = VALUE_W'(PHASES - p) << 27;
            span    = (p % 2 == 1) ? 15 : 4095;
            idle_on = (p % 4 != 3) && (p < PHASES - QUIET_PHASES);
            for (int n = 0; n < PHASE_BEATS; n++)
                random_beat(base, span);
        end
        @(negedge clk);
        start <= 1'b0;

        // Drain the awaited results, then wait for stray beats before the verdict.
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (fail_count == 0)
            $display("tb_sorted_top_k_list_unit: clean");
        else
            $display("tb_sorted_top_k_list_unit: errors");
        $finish;
    end

endmodule
